FILE: hdl/kmp_pkg.sv
package kmp_pkg;

  localparam int PriceW      = 16;
  localparam int ProfitW     = 31;
  localparam int HoldW       = 32;
  localparam int CfgW        = 5;
  localparam int TradesDef   = 16;
  localparam int TdataInW    = 16;
  localparam int TdataOutW   = 32;

  localparam logic [CfgW-1:0]    CfgReset = CfgW'(1);
  localparam logic [HoldW-1:0]   HoldMin  = {1'b1, {(HoldW-1){1'b0}}};
  localparam logic [ProfitW-1:0] SoldMax  = {ProfitW{1'b1}};

  // Per-step control shared by every cell of the chain
  typedef struct packed {
    logic adv;  // a price transaction is taken this cycle
    logic clr;  // the transaction closes the series
  } kmp_ctrl_t;

endpackage

FILE: hdl/kmp_cell.sv
module kmp_cell (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  kmp_pkg::kmp_ctrl_t          ctrl_i,
  input  logic [kmp_pkg::PriceW-1:0]  price_i,
  input  logic [kmp_pkg::ProfitW-1:0] sold_left_i,
  output logic [kmp_pkg::ProfitW-1:0] sold_o,
  output logic [kmp_pkg::ProfitW-1:0] sold_next_o
);
  import kmp_pkg::*;

  logic [HoldW-1:0]   hold_q, hold_d;
  logic [ProfitW-1:0] sold_q, sold_d;
  logic signed [HoldW:0] buy_val, hold_ext, sell_val, sold_ext, hold_new, sold_new;

  always_comb begin
    hold_ext = $signed({hold_q[HoldW-1], hold_q});
    sold_ext = $signed({2'b00, sold_q});
    buy_val  = $signed({2'b00, sold_left_i}) - $signed({{(HoldW+1-PriceW){1'b0}}, price_i});
    sell_val = hold_ext + $signed({{(HoldW+1-PriceW){1'b0}}, price_i});
    hold_new = (buy_val > hold_ext) ? buy_val : hold_ext;
    sold_new = (sell_val > sold_ext) ? sell_val : sold_ext;
    // sold_new is never negative since sold_q is not; clamp only the top
    if (sold_new > $signed({2'b00, SoldMax})) begin
      sold_next_o = SoldMax;
    end else begin
      sold_next_o = sold_new[ProfitW-1:0];
    end
    hold_d = hold_q;
    sold_d = sold_q;
    if (ctrl_i.adv) begin
      if (ctrl_i.clr) begin
        hold_d = HoldMin;
        sold_d = '0;
      end else begin
        hold_d = hold_new[HoldW-1:0];
        sold_d = sold_next_o;
      end
    end
  end

  assign sold_o = sold_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_q <= HoldMin;
      sold_q <= '0;
    end else begin
      hold_q <= hold_d;
      sold_q <= sold_d;
    end
  end

endmodule

FILE: hdl/k_transaction_max_profit_unit.sv
// Best profit from at most max_trades buy-sell transactions over a price series.
// Input stream: one price per transaction in s_axis_tdata, s_axis_tlast marks
// the final price of a series. Output stream: one profit per series, sent on
// the transaction that carries tlast.
// Throughput: one price per cycle while s_axis_tready is high. Every cell of
// the chain updates its holding and sold value from its left neighbor's
// previous value in the cycle a price is taken, so the rate is set by the
// registered cell update. The profit appears in the output register in the
// cycle after the last price is taken.
// cfg_we_i writes max_trades (0 gives a profit of 0; values above MAX_TRADES
// act as MAX_TRADES). Write it only while no series is in flight.
// Reset: max_trades returns to 1, all cells clear, no result is pending.
// Stall: while a profit waits on a low m_axis_tready, s_axis_tready is low and
// no price is taken; s_axis_tready drops only when the output register is full
// and not being emptied, so a price may enter in the cycle the profit leaves.
// After each last price the cells clear for the next series.
module k_transaction_max_profit_unit #(
  parameter int MAX_TRADES = kmp_pkg::TradesDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [kmp_pkg::CfgW-1:0]      cfg_wdata_i,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [kmp_pkg::TdataInW-1:0]  s_axis_tdata,   // [15:0] price
  input  logic                          s_axis_tlast,   // last_day
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [kmp_pkg::TdataOutW-1:0] m_axis_tdata    // [30:0] profit, [31] zero
);
  import kmp_pkg::*;

  localparam int IdxW = (MAX_TRADES > 1) ? $clog2(MAX_TRADES) : 1;

  logic [CfgW-1:0]    trades_q;
  logic               out_valid_q;
  logic [ProfitW-1:0] out_q, out_d;
  logic               take;
  kmp_ctrl_t          ctrl;
  logic [31:0]        limit;
  logic [IdxW-1:0]    sel;
  logic [ProfitW-1:0] sold_chain [MAX_TRADES+1];
  logic [ProfitW-1:0] sold_next  [MAX_TRADES];

  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign take          = s_axis_tvalid && s_axis_tready;
  assign ctrl          = kmp_ctrl_t'{adv: take, clr: s_axis_tlast};

  assign sold_chain[0] = '0;

  for (genvar j = 0; j < MAX_TRADES; j++) begin : g_cell
    kmp_cell u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .ctrl_i      (ctrl),
      .price_i     (s_axis_tdata[PriceW-1:0]),
      .sold_left_i (sold_chain[j]),
      .sold_o      (sold_chain[j+1]),
      .sold_next_o (sold_next[j])
    );
  end

  // Saturate the configured limit to the chain length
  always_comb begin
    if (32'(trades_q) > 32'(MAX_TRADES)) begin
      limit = 32'(MAX_TRADES);
    end else begin
      limit = 32'(trades_q);
    end
    sel = IdxW'(limit - 32'd1);
    if (limit == 32'd0) begin
      out_d = '0;
    end else begin
      out_d = sold_next[sel];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      trades_q    <= CfgReset;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        trades_q <= cfg_wdata_i;
      end
      if (take && s_axis_tlast) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take && s_axis_tlast) begin
      out_q <= out_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{(TdataOutW-ProfitW){1'b0}}, out_q};

endmodule

FILE: test/tb_k_transaction_max_profit_unit.sv
module tb_k_transaction_max_profit_unit;
  import kmp_pkg::*;

  localparam int Cells         = TradesDef;
  localparam int HalfPeriod    = 2;
  localparam int LimitCycles   = 400_000;
  localparam int HoldOffCycles = 80;
  localparam int SettleCycles  = 4;
  localparam int ChunkItems    = 85;

  localparam longint HoldFloor = -64'sd2147483648;
  localparam longint HoldCeil  = 64'sd2147483647;
  localparam longint SoldCeil  = 64'sd2147483647;

  // Tracks the per-count DP cells and the profits still owed by the block
  class profit_book;
    logic [CfgW-1:0]    trade_limit;
    longint             hold_val[Cells];
    longint             sold_val[Cells];
    logic [ProfitW-1:0] profit_q[$];
    int                 errors;
    int                 prices;
    int                 series;
    int                 checked;
    int                 writes;

    function new();
      trade_limit = CfgReset;
      clear_cells();
    endfunction

    function void clear_cells();
      foreach (hold_val[j]) begin
        hold_val[j] = HoldFloor;
        sold_val[j] = 0;
      end
    endfunction

    function void write_limit(logic [CfgW-1:0] lim);
      trade_limit = lim;
      writes++;
    endfunction

    function int pending();
      return profit_q.size();
    endfunction

    function void note_price(logic [PriceW-1:0] price, logic is_last);
      longint next_hold[Cells];
      longint next_sold[Cells];
      longint p;
      longint left;
      longint h;
      longint s;
      int     lim;
      p = price;
      foreach (hold_val[j]) begin
        left = (j == 0) ? 0 : sold_val[j-1];
        h = left - p;
        if (hold_val[j] > h) h = hold_val[j];
        s = hold_val[j] + p;
        if (sold_val[j] > s) s = sold_val[j];
        if (h < HoldFloor) h = HoldFloor;
        if (h > HoldCeil) h = HoldCeil;
        if (s < 0) s = 0;
        if (s > SoldCeil) s = SoldCeil;
        next_hold[j] = h;
        next_sold[j] = s;
      end
      hold_val = next_hold;
      sold_val = next_sold;
      prices++;
      if (is_last) begin
        lim = (trade_limit > Cells) ? Cells : int'(trade_limit);
        profit_q.push_back((lim == 0) ? '0 : ProfitW'(sold_val[lim-1]));
        series++;
        clear_cells();
      end
    endfunction

    task report_mismatch(string msg);
      $display("mismatch: %s", msg);
      errors++;
    endtask

    task check_profit(logic [TdataOutW-1:0] beat);
      logic [ProfitW-1:0] want;
      if (profit_q.size() == 0) begin
        report_mismatch($sformatf("profit %0d with none expected", beat[ProfitW-1:0]));
        return;
      end
      want = profit_q.pop_front();
      checked++;
      if (beat[ProfitW-1:0] !== want)
        report_mismatch($sformatf("profit got %0d want %0d", beat[ProfitW-1:0], want));
      if (beat[TdataOutW-1:ProfitW] !== '0)
        report_mismatch($sformatf("pad bits of tdata not zero: %h", beat));
    endtask

    task close_out();
      if (profit_q.size() != 0)
        report_mismatch($sformatf("%0d profits never arrived", profit_q.size()));
    endtask
  endclass

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CfgW-1:0]       cfg_wdata_i;
  logic                  s_axis_tvalid;
  logic                  s_axis_tready;
  logic [TdataInW-1:0]   s_axis_tdata;
  logic                  s_axis_tlast;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready;
  logic [TdataOutW-1:0]  m_axis_tdata;

  profit_book book = new();
  int         src_idle_pct = 0;
  int         snk_idle_pct = 0;
  bit         hold_req = 1'b0;

  k_transaction_max_profit_unit DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always #HalfPeriod clk_i = ~clk_i;

  initial begin
    #(LimitCycles * 2 * HalfPeriod);
    $display("[k_transaction_max_profit_unit] ERROR");
    $finish;
  end

  // Receiver: random backpressure, or a long hold-off when requested
  initial begin
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        hold_req = 1'b0;
        m_axis_tready <= 1'b0;
        repeat (HoldOffCycles) @(negedge clk_i);
      end else begin
        m_axis_tready <= ($urandom_range(99) >= snk_idle_pct);
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) book.check_profit(m_axis_tdata);
  end

  task automatic push_price(logic [PriceW-1:0] price, logic is_last);
    @(negedge clk_i);
    while ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= price;
    s_axis_tlast  <= is_last;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    book.note_price(price, is_last);
  endtask

  // Drop valid, wait for every owed profit, then let the block settle
  task automatic drain();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (book.pending() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic set_trade_limit(logic [CfgW-1:0] lim);
    drain();
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= lim;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    book.write_limit(lim);
  endtask

  task automatic play_series(int len);
    int                style;
    int                base;
    logic [PriceW-1:0] price;
    style = $urandom_range(3);
    base  = $urandom_range(65535);
    for (int i = 0; i < len; i++) begin
      case (style)
        0: price = PriceW'($urandom);
        1: price = (i % 2) ? PriceW'($urandom_range(65535, 65280))
                           : PriceW'($urandom_range(255));
        2: price = PriceW'(base ^ $urandom_range(15));
        default: price = PriceW'(base - i * 37);
      endcase
      push_price(price, i == len - 1);
    end
  endtask

  function automatic int pick_len();
    if ($urandom_range(19) == 0) return $urandom_range(100, 300);
    return $urandom_range(1, 20);
  endfunction

  function automatic logic [CfgW-1:0] pick_limit(int k);
    case (k % 6)
      0: return CfgW'(Cells);
      1: return '1;
      2: return '0;
      3: return CfgW'(1);
      4: return CfgW'($urandom_range(2, Cells - 1));
      default: return CfgW'($urandom_range(Cells + 1, 30));
    endcase
  endfunction

  task automatic run_chunk(logic [CfgW-1:0] lim, bit squeeze);
    int sent;
    int len;
    set_trade_limit(lim);
    sent = 0;
    if (squeeze) begin
      // hold the output while short series pile up behind it
      hold_req = 1'b1;
      repeat (30) begin
        len = $urandom_range(1, 2);
        play_series(len);
        sent += len;
      end
    end
    while (sent < ChunkItems) begin
      len = pick_len();
      play_series(len);
      sent += len;
    end
  endtask

  initial begin
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tlast  = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_wdata_i   = '0;
    rst_ni        = 1'b0;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // limit of one from reset
    push_price(16'd5, 1'b0);
    push_price(16'd1, 1'b0);
    push_price(16'd9, 1'b0);
    push_price(16'd3, 1'b0);
    push_price(16'hFFFF, 1'b1);
    // single price series
    push_price(16'hFFFF, 1'b1);

    set_trade_limit('0);
    for (int i = 0; i < 4; i++) push_price(PriceW'((i % 2) ? 100 * i : i), i == 3);
    set_trade_limit(CfgW'(2));
    for (int i = 0; i < 4; i++) push_price(PriceW'((i % 2) ? 100 * i : i), i == 3);
    // limit above the cell count saturates
    set_trade_limit('1);
    for (int i = 0; i < 12; i++) push_price((i % 2) ? 16'hFFFF : 16'h0000, i == 11);

    for (int stage = 0; stage < 3; stage++) begin
      src_idle_pct = (stage == 0) ? 9 : (stage == 1) ? 60 : 0;
      snk_idle_pct = (stage == 0) ? 60 : (stage == 1) ? 9 : 0;
      for (int c = 0; c < 4; c++) run_chunk(pick_limit(stage * 4 + c), c == 0);
    end

    drain();
    book.close_out();
    $display("covered %0d prices in %0d series under %0d limit writes",
             book.prices, book.series, book.writes);
    $display("checked %0d profits, %0d mismatches", book.checked, book.errors);
    if (book.errors == 0) begin
      $display("[k_transaction_max_profit_unit] OK");
    end else begin
      $display("[k_transaction_max_profit_unit] ERROR");
    end
    $finish;
  end

endmodule
